// ===== rtl/tach_pkg.sv =====
package tach_pkg;

  // Field widths
  localparam int TS_W      = 16;
  localparam int TPS_W     = 16;
  localparam int MARKS_W   = 8;
  localparam int WIN_W     = 5;
  localparam int SPEED_W   = 16;
  localparam int FRAC_W    = 8;
  localparam int DEN_W     = TS_W + MARKS_W;
  localparam int DIV_W     = TPS_W + FRAC_W;
  // A window sum holds at most 31 samples of 16 bits
  localparam int SUM_W     = SPEED_W + WIN_W;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GLITCH = 2'd0,
    REG_TPS    = 2'd1,
    REG_MARKS  = 2'd2,
    REG_WINDOW = 2'd3
  } cfg_reg_t;

  localparam logic [TS_W-1:0]    GLITCH_RST = 16'd50;
  localparam logic [TPS_W-1:0]   TPS_RST    = 16'd15625;
  localparam logic [MARKS_W-1:0] MARKS_RST  = 8'd10;
  localparam logic [WIN_W-1:0]   WINDOW_RST = 5'd5;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int JOB_QUEUE_DEPTH   = 2;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // One classified edge, handed from the front to the back
  typedef struct packed {
    logic             ch;
    logic             acc;
    logic [DEN_W-1:0] den;
  } job_t;

endpackage

// ===== rtl/tach_front.sv =====
module tach_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_ch,
  input  logic [tach_pkg::TS_W-1:0]  in_ts,
  input  logic [tach_pkg::TS_W-1:0]  glitch_threshold,
  input  logic [tach_pkg::MARKS_W-1:0] marks_per_rev,
  output logic                       push,
  output tach_pkg::job_t             push_job,
  input  logic                       queue_full
);
  import tach_pkg::*;

  logic [TS_W-1:0] last_r [2];
  logic            stg_vld_r;
  logic            stg_ch_r;
  logic            stg_acc_r;
  logic [TS_W-1:0] stg_elapsed_r;
  logic [TS_W-1:0] elapsed;
  logic            take;

  assign in_ready = !stg_vld_r || !queue_full;
  assign take     = in_valid && in_ready;
  assign elapsed  = in_ts - last_r[in_ch];
  assign push     = stg_vld_r && !queue_full;

  // Form the speed divisor from the staged period
  always_comb begin
    push_job.ch  = stg_ch_r;
    push_job.acc = stg_acc_r;
    push_job.den = DEN_W'(stg_elapsed_r) * DEN_W'(marks_per_rev);
  end

  // Hold the last stamp per channel and stage the classified edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r[0] <= '0;
      last_r[1] <= '0;
      stg_vld_r <= 1'b0;
    end else begin
      if (take) begin
        last_r[in_ch] <= in_ts;
        stg_vld_r     <= 1'b1;
      end else if (push) begin
        stg_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_ch_r      <= in_ch;
      stg_acc_r     <= elapsed > glitch_threshold;
      stg_elapsed_r <= elapsed;
    end
  end

endmodule

// ===== rtl/tach_queue.sv =====
module tach_queue #(
  parameter int DEPTH = tach_pkg::JOB_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tach_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tach_pkg::job_t pop_job
);
  import tach_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = q_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/tach_div.sv =====
module tach_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tach_pkg::DIV_W-1:0] dividend,
  input  logic [tach_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [tach_pkg::DIV_W-1:0] quotient
);
  import tach_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dsr_r;
  logic [DIV_W:0]   shifted;
  logic             ge;
  logic [DIV_W:0]   diff;

  // One restoring step per cycle; a zero divisor yields all ones
  assign shifted  = {rem_r, quo_r[DIV_W-1]};
  assign ge       = shifted >= {1'b0, dsr_r};
  assign diff     = shifted - {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/tach_back.sv =====
module tach_back #(
  parameter int HISTORY_DEPTH = tach_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_empty,
  input  tach_pkg::job_t               job,
  output logic                         job_pop,
  input  logic [tach_pkg::TPS_W-1:0]   ticks_per_second,
  input  logic [tach_pkg::WIN_W-1:0]   window_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ch,
  output logic                         out_acc,
  output logic [tach_pkg::SPEED_W-1:0] out_speed,
  output logic [tach_pkg::SPEED_W-1:0] out_chan_avg,
  output logic [tach_pkg::SPEED_W-1:0] out_comb_avg
);
  import tach_pkg::*;

  localparam int PW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEED,
    ST_WSETUP,
    ST_WALK,
    ST_MEAN
  } state_t;

  state_t             state_r;
  logic               ch_r;
  logic               acc_r;
  logic [SPEED_W-1:0] speed_r;
  logic [WIN_W-1:0]   w_r;
  logic [PW-1:0]      wp_r [2];
  logic               walk_ch_r;
  logic [PW-1:0]      pos_r;
  logic [WIN_W-1:0]   issue_cnt_r;
  logic               rd_pend_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SPEED_W-1:0] avg0_r;
  logic               out_vld_r;
  logic               out_ch_r;
  logic               out_acc_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic [SPEED_W-1:0] out_chan_r;
  logic [SPEED_W-1:0] out_comb_r;

  logic               div_go_r;
  logic [DIV_W-1:0]   div_a_r;
  logic [DIV_W-1:0]   div_b_r;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;

  logic [SPEED_W-1:0] hist_mem_r [2][HISTORY_DEPTH];
  logic               hist_vld_r [2][HISTORY_DEPTH];
  logic [SPEED_W-1:0] rd_data_r;
  logic               rd_hit_r;

  logic [WIN_W-1:0]   w_eff;
  logic [SPEED_W-1:0] spd_sat;
  logic [PW-1:0]      wp_inc;
  logic               wr_en;
  logic               issue;
  logic [SPEED_W:0]   comb_sum;

  tach_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Clamp the window to 1..HISTORY_DEPTH
  always_comb begin
    w_eff = window_length;
    if (window_length == '0) begin
      w_eff = WIN_W'(1);
    end else if (32'(window_length) > HISTORY_DEPTH) begin
      w_eff = WIN_W'(HISTORY_DEPTH);
    end
  end

  assign spd_sat  = (div_q > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_q[SPEED_W-1:0];
  assign wp_inc   = (wp_r[ch_r] == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_r[ch_r] + 1'b1;
  assign wr_en    = (state_r == ST_SPEED) && div_done;
  assign issue    = (state_r == ST_WALK) && (issue_cnt_r != w_r);
  assign comb_sum = {1'b0, avg0_r} + {1'b0, div_q[SPEED_W-1:0]};
  assign job_pop  = (state_r == ST_IDLE) && !job_empty && !out_vld_r;

  assign out_valid    = out_vld_r;
  assign out_ch       = out_ch_r;
  assign out_acc      = out_acc_r;
  assign out_speed    = out_speed_r;
  assign out_chan_avg = out_chan_r;
  assign out_comb_avg = out_comb_r;

  // Sequence one edge: speed division and store if accepted, then walk and divide each window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r[0]   <= '0;
      wp_r[1]   <= '0;
      div_go_r  <= 1'b0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      div_go_r  <= 1'b0;
      rd_pend_r <= issue;
      if (out_vld_r && out_ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (job_pop) begin
            ch_r      <= job.ch;
            acc_r     <= job.acc;
            speed_r   <= '0;
            w_r       <= w_eff;
            walk_ch_r <= 1'b0;
            div_a_r   <= {ticks_per_second, FRAC_W'(0)};
            div_b_r   <= job.den;
            div_go_r  <= job.acc;
            state_r   <= job.acc ? ST_SPEED : ST_WSETUP;
          end
        end
        ST_SPEED: begin
          if (div_done) begin
            speed_r    <= spd_sat;
            wp_r[ch_r] <= wp_inc;
            state_r    <= ST_WSETUP;
          end
        end
        ST_WSETUP: begin
          pos_r       <= wp_r[walk_ch_r];
          issue_cnt_r <= '0;
          sum_r       <= '0;
          state_r     <= ST_WALK;
        end
        ST_WALK: begin
          if (issue) begin
            pos_r       <= (pos_r == '0) ? PW'(HISTORY_DEPTH - 1) : pos_r - 1'b1;
            issue_cnt_r <= issue_cnt_r + 1'b1;
          end
          if (rd_pend_r && rd_hit_r) begin
            sum_r <= sum_r + SUM_W'(rd_data_r);
          end
          if (!issue && !rd_pend_r) begin
            div_a_r  <= DIV_W'(sum_r);
            div_b_r  <= DIV_W'(w_r);
            div_go_r <= 1'b1;
            state_r  <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            if (!walk_ch_r) begin
              avg0_r    <= div_q[SPEED_W-1:0];
              walk_ch_r <= 1'b1;
              state_r   <= ST_WSETUP;
            end else begin
              out_ch_r    <= ch_r;
              out_acc_r   <= acc_r;
              out_speed_r <= speed_r;
              out_chan_r  <= ch_r ? div_q[SPEED_W-1:0] : avg0_r;
              out_comb_r  <= comb_sum[SPEED_W:1];
              out_vld_r   <= 1'b1;
              state_r     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // History memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem_r[ch_r][wp_inc] <= spd_sat;
    end
    if (issue) begin
      rd_data_r <= hist_mem_r[walk_ch_r][pos_r];
    end
  end

  // Written flags: an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          hist_vld_r[c][i] <= 1'b0;
        end
      end
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        hist_vld_r[ch_r][wp_inc] <= 1'b1;
      end
      if (issue) begin
        rd_hit_r <= hist_vld_r[walk_ch_r][pos_r];
      end
    end
  end

endmodule

// ===== rtl/dual_tachometer_period_average.sv =====
// Channel  Dir  Handshake                    Payload
// in_      in   in_tvalid / in_tready        tuser: channel; tdata: timestamp
// out_     out  out_tvalid / out_tready      tuser: source_channel, accepted;
//                                            tdata: speeds and averages
// cfg_     in   cfg_we (no wait)             cfg_addr selects, cfg_wdata holds value
//
// The front stages and classifies an edge, then pushes it when the queue is not full.
// The back handles one edge at a time: a window walk and mean division for each
// channel, plus a speed division when the edge is accepted (24-step serial
// divider); the shared divider and the one-port history walk set its pace.
// Reset (rst_n low, synchronous) clears stamps, write positions and history flags.
// The front stage and a two-entry queue take edges while the back is busy.
module dual_tachometer_period_average #(
  parameter int HISTORY_DEPTH = tach_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tach_pkg::TS_W-1:0]       in_tdata,   // [15:0] timestamp
  input  logic                            in_tuser,   // [0] channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] edge_speed, [31:16] channel_average, [47:32] combined_average
  output logic [3*tach_pkg::SPEED_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser,  // [0] source_channel, [1] accepted
  input  logic                            cfg_we,
  input  logic [tach_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tach_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tach_pkg::*;

  logic [TS_W-1:0]    glitch_r;
  logic [TPS_W-1:0]   tps_r;
  logic [MARKS_W-1:0] marks_r;
  logic [WIN_W-1:0]   window_r;

  logic               push;
  job_t               push_job;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  job_t               q_job;

  logic               res_ch;
  logic               res_acc;
  logic [SPEED_W-1:0] res_speed;
  logic [SPEED_W-1:0] res_chan;
  logic [SPEED_W-1:0] res_comb;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_r <= GLITCH_RST;
      tps_r    <= TPS_RST;
      marks_r  <= MARKS_RST;
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GLITCH: glitch_r <= cfg_wdata[TS_W-1:0];
        REG_TPS:    tps_r    <= cfg_wdata[TPS_W-1:0];
        REG_MARKS:  marks_r  <= cfg_wdata[MARKS_W-1:0];
        REG_WINDOW: window_r <= cfg_wdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tach_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_ch            (in_tuser),
    .in_ts            (in_tdata),
    .glitch_threshold (glitch_r),
    .marks_per_rev    (marks_r),
    .push             (push),
    .push_job         (push_job),
    .queue_full       (q_full)
  );

  tach_queue #(
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (q_job)
  );

  tach_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_empty        (q_empty),
    .job              (q_job),
    .job_pop          (q_pop),
    .ticks_per_second (tps_r),
    .window_length    (window_r),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_ch           (res_ch),
    .out_acc          (res_acc),
    .out_speed        (res_speed),
    .out_chan_avg     (res_chan),
    .out_comb_avg     (res_comb)
  );

  assign out_tdata = {res_comb, res_chan, res_speed};
  assign out_tuser = {res_acc, res_ch};

endmodule
